FILE: src/dlr_pkg.sv
// Shared types and constants of the DDA line rasterizer.
`default_nettype none

package dlr_pkg;

  localparam int IN_COORD_W = 10;
  localparam int ADDR_W     = 20;
  localparam int COLOR_W    = 24;
  localparam int IN_DATA_W  = 4 * IN_COORD_W;
  localparam int OUT_DATA_W = 2 * IN_COORD_W + ADDR_W + COLOR_W;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hC5F442;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_t;

endpackage

`default_nettype wire

FILE: src/dlr_divider.sv
// Iterative restoring divider that produces the minor-axis slope one bit per cycle.
`default_nettype none

module dlr_divider #(
  parameter int COORD_BITS    = 10,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [COORD_BITS-1:0]    minor_len,
  input  wire logic [COORD_BITS-1:0]    major_len,
  output logic                          done,
  output logic [FRACTION_BITS:0]        quotient
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [COORD_BITS:0]    rem_r;
  logic [COORD_BITS-1:0]  div_r;
  logic [FRACTION_BITS:0] quo_r;

  logic                   ge;
  logic [COORD_BITS:0]    diff;

  // After each subtract step the remainder is below the divisor, so doubling it never overflows.
  assign ge   = (rem_r >= {1'b0, div_r}) && (div_r != '0);
  assign diff = ge ? (rem_r - {1'b0, div_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      div_r  <= '0;
      quo_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRACTION_BITS);
        rem_r  <= {1'b0, minor_len};
        div_r  <= major_len;
        quo_r  <= '0;
      end else if (busy_r) begin
        quo_r <= {quo_r[FRACTION_BITS-1:0], ge};
        rem_r <= {diff[COORD_BITS-1:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: src/dda_line_rasterizer.sv
// Top level of the DDA line rasterizer: load sequencer, stepping datapath and output register.
// A load item (in_tuser low) carries the two endpoints in in_tdata. The block then
// computes the minor-axis slope with a single divider that resolves one quotient bit
// per cycle; a load holds in_tready low until the divider is done and gives no
// result. An advance item (in_tuser high), while a line is active, places one
// pixel in the output register: column, row, frame-buffer address, color and
// out_tlast on the final pixel of the line. Advances stream at one item per cycle
// while the output is not stalled. An advance with no active line gives nothing.
// The output register accepts a new pixel in the same cycle that the old one is taken;
// while a pixel waits and out_tready stays low, in_tready stays low and nothing is lost.
// The color register is written through the cfg channel, which is always ready and
// should be used only while the block is idle.
// Reset clears the line state, empties the output register and restores the
// default color.
`default_nettype none

module dda_line_rasterizer #(
  parameter int WINDOW_WIDTH  = 1024,
  parameter int COORD_BITS    = 10,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [dlr_pkg::IN_DATA_W-1:0]    in_tdata,
  // action
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // pixel_x, pixel_y, pixel_address, pixel_color
  output logic [dlr_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dlr_pkg::COLOR_W-1:0]      cfg_data
);

  localparam int IW    = dlr_pkg::IN_COORD_W;
  localparam int AW    = dlr_pkg::ADDR_W;
  localparam int FIX_W = COORD_BITS + FRACTION_BITS + 1;
  localparam logic [AW-1:0]    WIDTH_K = AW'(WINDOW_WIDTH);
  localparam logic [FIX_W-1:0] HALF_K  = FIX_W'(1) << (FRACTION_BITS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_DIVIDE
  } state_t;

  state_t                        state_r;
  logic [dlr_pkg::COLOR_W-1:0]   color_r;
  logic [COORD_BITS-1:0]         major_pos_r;
  logic [FIX_W-1:0]              minor_pos_r;
  logic [FRACTION_BITS:0]        slope_r;
  logic                          x_neg_r;
  logic                          y_neg_r;
  logic                          x_major_r;
  logic [COORD_BITS:0]           left_r;
  logic                          active_r;
  logic                          out_valid_r;
  logic [IW-1:0]                 out_x_r;
  logic [IW-1:0]                 out_y_r;
  logic [AW-1:0]                 out_addr_r;
  logic [dlr_pkg::COLOR_W-1:0]   out_color_r;
  logic                          out_last_r;

  logic                          accept;
  logic                          do_load;
  logic                          do_step;
  logic [COORD_BITS-1:0]         sx, sy, ex, ey, lx, ly;
  logic                          ld_x_major;
  logic [COORD_BITS-1:0]         ld_major, ld_minor;
  logic [FIX_W-1:0]              rounded;
  logic [COORD_BITS-1:0]         minor_c;
  logic [COORD_BITS-1:0]         px, py;
  logic                          major_neg, minor_neg;
  logic [COORD_BITS:0]           left_nxt;
  logic [AW-1:0]                 addr_nxt;
  logic                          div_done;
  logic [FRACTION_BITS:0]        div_q;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign do_load   = accept && (dlr_pkg::action_t'(in_tuser) == dlr_pkg::ACT_LOAD);
  assign do_step   = accept && (dlr_pkg::action_t'(in_tuser) == dlr_pkg::ACT_ADVANCE)
                     && active_r;

  assign sx = COORD_BITS'(in_tdata[IW-1:0]);
  assign sy = COORD_BITS'(in_tdata[2*IW-1:IW]);
  assign ex = COORD_BITS'(in_tdata[3*IW-1:2*IW]);
  assign ey = COORD_BITS'(in_tdata[4*IW-1:3*IW]);
  assign lx = (ex >= sx) ? (ex - sx) : (sx - ex);
  assign ly = (ey >= sy) ? (ey - sy) : (sy - ey);
  assign ld_x_major = (ly <= lx);
  assign ld_major   = ld_x_major ? lx : ly;
  assign ld_minor   = ld_x_major ? ly : lx;

  assign rounded   = minor_pos_r + HALF_K;
  assign minor_c   = rounded[FRACTION_BITS +: COORD_BITS];
  assign px        = x_major_r ? major_pos_r : minor_c;
  assign py        = x_major_r ? minor_c : major_pos_r;
  assign major_neg = x_major_r ? x_neg_r : y_neg_r;
  assign minor_neg = x_major_r ? y_neg_r : x_neg_r;
  assign left_nxt  = left_r - 1'b1;
  assign addr_nxt  = AW'(px) + AW'(py) * WIDTH_K;

  dlr_divider #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (do_load),
    .minor_len (ld_minor),
    .major_len (ld_major),
    .done      (div_done),
    .quotient  (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      color_r     <= dlr_pkg::COLOR_RESET;
      major_pos_r <= '0;
      minor_pos_r <= '0;
      slope_r     <= '0;
      x_neg_r     <= 1'b0;
      y_neg_r     <= 1'b0;
      x_major_r   <= 1'b0;
      left_r      <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_addr_r  <= '0;
      out_color_r <= '0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        color_r <= cfg_data;
      end
      case (state_r)
        ST_IDLE: begin
          if (do_load) begin
            x_neg_r     <= (ex < sx);
            y_neg_r     <= (ey < sy);
            x_major_r   <= ld_x_major;
            major_pos_r <= ld_x_major ? sx : sy;
            minor_pos_r <= FIX_W'(ld_x_major ? sy : sx) << FRACTION_BITS;
            left_r      <= {1'b0, ld_major} + 1'b1;
            active_r    <= 1'b1;
            state_r     <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            slope_r <= div_q;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (do_step) begin
        out_valid_r <= 1'b1;
        out_x_r     <= IW'(px);
        out_y_r     <= IW'(py);
        out_addr_r  <= addr_nxt;
        out_color_r <= color_r;
        out_last_r  <= (left_nxt == '0);
        left_r      <= left_nxt;
        if (left_nxt == '0) begin
          active_r <= 1'b0;
        end
        major_pos_r <= major_neg ? (major_pos_r - 1'b1) : (major_pos_r + 1'b1);
        minor_pos_r <= minor_neg ? (minor_pos_r - FIX_W'(slope_r))
                                 : (minor_pos_r + FIX_W'(slope_r));
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_color_r, out_addr_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
